// ----- rtl/cnw_pkg.sv -----
// ----------------------------------------------------------------------------
// cnw_pkg: calendar normalize and weekday package
// Field bounds, month tables and the constants of the year arithmetic.
// ----------------------------------------------------------------------------
package cnw_pkg;

  localparam int unsigned SecBound   = 60;
  localparam int unsigned MinBound   = 60;
  localparam int unsigned HourBound  = 24;
  localparam int unsigned MonthBound = 12;
  localparam int unsigned WeekDays   = 7;

  // floor(y / 100) == (y * Div100Mul) >> Div100Shift for y below 1024.
  localparam int unsigned Div100Mul   = 1311;
  localparam int unsigned Div100Shift = 17;
  // floor(s / 7) == (s * Div7Mul) >> Div7Shift for s below 209.
  localparam int unsigned Div7Mul   = 147;
  localparam int unsigned Div7Shift = 10;

  localparam logic [3:0] MonFebruary = 4'd1;

  // Length of a month in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Month offset of the table method, with its own row for leap years.
  function automatic logic [2:0] month_off(input logic leap, input logic [3:0] mon);
    logic [2:0] off;
    case (mon)
      4'd0:    off = leap ? 3'd6 : 3'd0;
      4'd1:    off = leap ? 3'd2 : 3'd3;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd6;
      4'd4:    off = 3'd1;
      4'd5:    off = 3'd4;
      4'd6:    off = 3'd6;
      4'd7:    off = 3'd2;
      4'd8:    off = 3'd5;
      4'd9:    off = 3'd0;
      4'd10:   off = 3'd3;
      default: off = 3'd5;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/calendar_normalize_weekday_top.sv -----
// ----------------------------------------------------------------------------
// calendar_normalize_weekday_top: calendar time normalizer with weekday
// Wraps each time field by one step and computes the Gregorian day of week.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake         Payload
//  --------  ----------------  ---------------------------------------------
//  request   start / busy      second_in minute_in hour_in day_in month_in
//                              year_since_1900
//  result    done (strobe)     second_out minute_out hour_out day_out
//                              month_out year_out weekday
//
// Every request passes through the four register stages of the pipeline on
// its way from the accepting edge to its done strobe, and a new request may
// be accepted every cycle. busy is always low: the receiver cannot stall
// results, so nothing ever backs up. The synchronous reset clears the stage
// valid bits, dropping any request in flight; payload registers are not reset.
//
module calendar_normalize_weekday_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [6:0] second_in,
  input  logic signed [6:0] minute_in,
  input  logic signed [5:0] hour_in,
  input  logic signed [6:0] day_in,
  input  logic signed [4:0] month_in,
  input  logic        [9:0] year_since_1900,
  output logic              done,
  output logic        [5:0] second_out,
  output logic        [5:0] minute_out,
  output logic        [4:0] hour_out,
  output logic        [4:0] day_out,
  output logic        [3:0] month_out,
  output logic        [9:0] year_out,
  output logic        [2:0] weekday
);
  import cnw_pkg::*;

  // Stage 1: wrap the fixed-bound fields and start the divide by 100 of the
  // year offset. The full year is 1900 plus the offset, and 1900 is a multiple
  // of 100 and of 4, so all year tests work on the offset alone.
  logic              v1;
  logic        [5:0] s1_sec, s1_min;
  logic        [4:0] s1_hour;
  logic        [3:0] s1_mon;
  logic signed [6:0] s1_day;
  logic        [9:0] s1_y;
  logic       [20:0] s1_prod;

  // Stage 2: century split, leap test, day wrap and month offset.
  logic              v2;
  logic        [5:0] s2_sec, s2_min;
  logic        [4:0] s2_hour, s2_day;
  logic        [3:0] s2_mon;
  logic        [9:0] s2_y;
  logic        [2:0] s2_off, s2_cent;
  logic        [6:0] s2_yy;

  // Stage 3: the weekday sum before reduction modulo 7.
  logic              v3;
  logic        [5:0] s3_sec, s3_min;
  logic        [4:0] s3_hour, s3_day;
  logic        [3:0] s3_mon;
  logic        [9:0] s3_y;
  logic        [7:0] s3_sum;

  // Combinational values between stages.
  logic        [5:0] sec_w, min_w;
  logic        [4:0] hour_w;
  logic        [3:0] mon_w;
  logic        [3:0] cen_q;
  logic        [9:0] yy_full;
  logic              leap;
  logic        [4:0] mlen;
  logic        [4:0] day_w;
  logic        [1:0] cen_mod;
  logic        [7:0] sum;
  logic       [17:0] prod7;
  logic        [4:0] q7;
  logic        [7:0] wd_full;

  assign busy = 1'b0;

  // A negative field becomes bound minus one and a field at or above its
  // bound becomes zero, however far out it lies.
  always_comb begin
    if (second_in[6]) begin
      sec_w = 6'(SecBound - 1);
    end else if (second_in[5:0] >= 6'(SecBound)) begin
      sec_w = '0;
    end else begin
      sec_w = second_in[5:0];
    end
    if (minute_in[6]) begin
      min_w = 6'(MinBound - 1);
    end else if (minute_in[5:0] >= 6'(MinBound)) begin
      min_w = '0;
    end else begin
      min_w = minute_in[5:0];
    end
    if (hour_in[5]) begin
      hour_w = 5'(HourBound - 1);
    end else if (hour_in[4:0] >= 5'(HourBound)) begin
      hour_w = '0;
    end else begin
      hour_w = hour_in[4:0];
    end
    if (month_in[4]) begin
      mon_w = 4'(MonthBound - 1);
    end else if (month_in[3:0] >= 4'(MonthBound)) begin
      mon_w = '0;
    end else begin
      mon_w = month_in[3:0];
    end
  end

  // Stage 2 logic. The offset splits into centuries past 1900 and the two-digit
  // year. A year is a century year when the two-digit year is zero, and it is
  // divisible by 400 when 19 plus the centuries past 1900 is, that is when the
  // centuries past 1900 leave a remainder of one modulo four.
  always_comb begin
    cen_q   = s1_prod[Div100Shift +: 4];
    yy_full = s1_y - 10'(cen_q) * 10'd100;
    leap    = (s1_y[1:0] == 2'b00) && ((yy_full != '0) || (cen_q[1:0] == 2'b01));
    mlen    = month_len(s1_mon) + 5'((leap && (s1_mon == MonFebruary)) ? 1 : 0);
    // The day bound is the month length plus one, so day zero passes through.
    if (s1_day[6]) begin
      day_w = mlen;
    end else if (s1_day[5:0] > {1'b0, mlen}) begin
      day_w = '0;
    end else begin
      day_w = s1_day[4:0];
    end
    // The full-year century index is 19 + cen_q, taken modulo four.
    cen_mod = cen_q[1:0] + 2'd3;
  end

  // Stage 3 logic: day + month offset + yy + yy/4 + century code.
  assign sum = 8'(s2_day) + 8'(s2_off) + 8'(s2_yy) + 8'(s2_yy >> 2) + 8'(s2_cent);

  // Stage 4 logic: the sum stays below 209, so a reciprocal gives the quotient.
  always_comb begin
    prod7   = 18'(s3_sum) * 18'(Div7Mul);
    q7      = prod7[Div7Shift +: 5];
    wd_full = s3_sum - 8'(q7) * 8'(WeekDays);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end

    s1_sec  <= sec_w;
    s1_min  <= min_w;
    s1_hour <= hour_w;
    s1_mon  <= mon_w;
    s1_day  <= day_in;
    s1_y    <= year_since_1900;
    s1_prod <= 21'(year_since_1900) * 21'(Div100Mul);

    s2_sec  <= s1_sec;
    s2_min  <= s1_min;
    s2_hour <= s1_hour;
    s2_mon  <= s1_mon;
    s2_day  <= day_w;
    s2_y    <= s1_y;
    s2_off  <= month_off(leap, s1_mon);
    s2_yy   <= yy_full[6:0];
    s2_cent <= {2'(2'd3 - cen_mod), 1'b0};

    s3_sec  <= s2_sec;
    s3_min  <= s2_min;
    s3_hour <= s2_hour;
    s3_day  <= s2_day;
    s3_mon  <= s2_mon;
    s3_y    <= s2_y;
    s3_sum  <= sum;

    second_out <= s3_sec;
    minute_out <= s3_min;
    hour_out   <= s3_hour;
    day_out    <= s3_day;
    month_out  <= s3_mon;
    year_out   <= s3_y;
    weekday    <= wd_full[2:0];
  end

`ifndef SYNTHESIS
  // Every accepted request comes out with a done strobe.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##4 done)
    else $error("request did not reach the result strobe in four cycles");

  // No strobe appears without a matching accepted request.
  assert property (@(posedge clk) disable iff (rst)
                   done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching request");

  // Month, hour and weekday are in range, and February never runs past day 29.
  assert property (@(posedge clk) disable iff (rst)
                   done |-> (month_out < 4'd12) && (hour_out < 5'd24) && (weekday < 3'd7)
                            && ((month_out != MonFebruary) || (day_out <= 5'd29)))
    else $error("result field out of range");
`endif

endmodule
